[rtl/unp_pkg.sv]
// ----------------------------------------------------------------------------
// unp_pkg
// Shared constants, register indexes, types and arithmetic step functions
// for the omnidirectional pixel unprojection pipeline.
// ----------------------------------------------------------------------------
package unp_pkg;

    localparam int POLY_TERMS_MAX = 6;
    localparam int NUM_REGS       = 7;

    localparam logic [2:0] REG_PRINCIPAL = 3'd0;
    localparam logic [2:0] REG_AFF_ROW0  = 3'd1;
    localparam logic [2:0] REG_AFF_ROW1  = 3'd2;
    localparam logic [2:0] REG_POLY01    = 3'd3;
    localparam logic [2:0] REG_POLY23    = 3'd4;
    localparam logic [2:0] REG_POLY45    = 3'd5;
    localparam logic [2:0] REG_TERMS     = 3'd6;

    // two root bits per stage, 32 root bits
    localparam int SQ_STAGES  = 16;
    // two quotient bits per stage, 32 quotient bits
    localparam int DIV_STAGES = 16;

    typedef struct packed {
        logic [63:0]                      principal;
        logic [63:0]                      row0;
        logic [63:0]                      row1;
        logic [POLY_TERMS_MAX-1:0][31:0]  coef;   // coef[i] = a_i
        logic [2:0]                       terms;  // already clamped
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic signed [38:0] x;
        logic signed [38:0] y;
        logic [31:0]        r;
    } t_xyr;

    typedef struct packed {
        logic               valid;
        logic signed [38:0] x;
        logic signed [38:0] y;
        logic signed [31:0] z;
    } t_xyz;

    // integer square root, remainder form
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

    // restoring division
    typedef struct packed {
        logic [31:0] low;
        logic [30:0] rem;
        logic [31:0] quo;
    } t_dv;

    function automatic t_sq sq_step(input t_sq s);
        logic [35:0] t;
        logic [35:0] trial;
        t_sq         o;
        t     = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (t >= trial) begin
            o.rem  = 34'(t - trial);
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = t[33:0];
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv div_step(input t_dv s, input logic [30:0] d);
        logic [31:0] t;
        t_dv         o;
        t     = {s.rem, s.low[31]};
        o.low = {s.low[30:0], 1'b0};
        if (t >= {1'b0, d}) begin
            o.rem = 31'(t - {1'b0, d});
            o.quo = {s.quo[30:0], 1'b1};
        end else begin
            o.rem = t[30:0];
            o.quo = {s.quo[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

[rtl/unp_if.sv]
// ----------------------------------------------------------------------------
// unp channel interfaces
// Pixel input, bearing output and configuration write channels.
// ----------------------------------------------------------------------------
interface unp_pix_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_u;
    logic [11:0] pixel_v;
    modport source (output valid, output pixel_u, output pixel_v, input ready);
    modport sink   (input valid, input pixel_u, input pixel_v, output ready);
endinterface

interface unp_bear_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] bearing_x;
    logic signed [31:0] bearing_y;
    logic signed [31:0] bearing_z;
    modport source (output valid, output bearing_x, output bearing_y, output bearing_z,
                    input ready);
    modport sink   (input valid, input bearing_x, input bearing_y, input bearing_z,
                    output ready);
endinterface

interface unp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/unp_front.sv]
// ----------------------------------------------------------------------------
// unp_front
// Principal point offset, inverse affine transform and pipelined radius
// square root.
// ----------------------------------------------------------------------------
module unp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [11:0]   i_u,
    input  logic [11:0]   i_v,
    input  unp_pkg::t_cfg i_cfg,
    output unp_pkg::t_xyr o_xyr
);
    import unp_pkg::*;

    logic signed [31:0] m00, m01, m10, m11;
    logic [31:0]        cx, cy;

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic signed [33:0]        r_dx, r_dy;
    logic signed [65:0]        r_p00, r_p01, r_p10, r_p11;
    logic signed [38:0]        r_x3, r_y3, r_x4, r_y4;
    logic [61:0]               r_sx, r_sy;
    logic [SQ_STAGES:0]        r_qv;
    t_sq                       r_sq [SQ_STAGES+1];
    logic signed [38:0]        r_qx [SQ_STAGES+1];
    logic signed [38:0]        r_qy [SQ_STAGES+1];

    logic signed [30:0] xs, ys;
    logic [30:0]        px, py;
    t_sq                n_sq0;

    assign cx  = i_cfg.principal[63:32];
    assign cy  = i_cfg.principal[31:0];
    assign m00 = $signed(i_cfg.row0[63:32]);
    assign m01 = $signed(i_cfg.row0[31:0]);
    assign m10 = $signed(i_cfg.row1[63:32]);
    assign m11 = $signed(i_cfg.row1[31:0]);

    always_comb begin
        xs = 31'(r_x3 >>> 8);
        ys = 31'(r_y3 >>> 8);
        px = xs[30] ? 31'(-xs) : 31'(xs);
        py = ys[30] ? 31'(-ys) : 31'(ys);
        n_sq0.rad  = 64'(r_sx) + 64'(r_sy);
        n_sq0.rem  = '0;
        n_sq0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_qv <= '0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_qv <= {r_qv[SQ_STAGES-1:0], r_v4};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= $signed({2'b00, i_u, 20'd0}) - $signed({2'b00, cx});
            r_dy  <= $signed({2'b00, i_v, 20'd0}) - $signed({2'b00, cy});
            r_p00 <= m00 * r_dx;
            r_p01 <= m01 * r_dy;
            r_p10 <= m10 * r_dx;
            r_p11 <= m11 * r_dy;
            r_x3  <= 39'((r_p00 >>> 28) + (r_p01 >>> 28));
            r_y3  <= 39'((r_p10 >>> 28) + (r_p11 >>> 28));
            r_sx  <= px * px;
            r_sy  <= py * py;
            r_x4  <= r_x3;
            r_y4  <= r_y3;
            r_sq[0] <= n_sq0;
            r_qx[0] <= r_x4;
            r_qy[0] <= r_y4;
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq[k+1] <= sq_step(sq_step(r_sq[k]));
                r_qx[k+1] <= r_qx[k];
                r_qy[k+1] <= r_qy[k];
            end
        end
    end

    assign o_xyr.valid = r_qv[SQ_STAGES];
    assign o_xyr.x     = r_qx[SQ_STAGES];
    assign o_xyr.y     = r_qy[SQ_STAGES];
    assign o_xyr.r     = r_sq[SQ_STAGES].root;

endmodule

[rtl/unp_horner.sv]
// ----------------------------------------------------------------------------
// unp_horner
// Polynomial in the normalized radius, one multiply and one add stage per
// coefficient, highest coefficient first.
// ----------------------------------------------------------------------------
module unp_horner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  unp_pkg::t_xyr i_xyr,
    input  unp_pkg::t_cfg i_cfg,
    output unp_pkg::t_xyz o_xyz
);
    import unp_pkg::*;

    typedef struct packed {
        logic               valid;
        logic signed [38:0] x;
        logic signed [38:0] y;
        logic [31:0]        r;
        logic signed [31:0] z;
    } t_hs;

    t_hs                r_m    [POLY_TERMS_MAX];
    logic signed [64:0] r_prod [POLY_TERMS_MAX];
    t_hs                r_a    [POLY_TERMS_MAX];
    t_hs                src    [POLY_TERMS_MAX];
    t_hs                n_a    [POLY_TERMS_MAX];

    function automatic logic signed [31:0] sat32(input logic signed [45:0] s);
        if (s > 46'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (s < -46'sd2147483648) return 32'sh8000_0000;
        else                           return 32'(s);
    endfunction

    always_comb begin
        src[0].valid = i_xyr.valid;
        src[0].x     = i_xyr.x;
        src[0].y     = i_xyr.y;
        src[0].r     = i_xyr.r;
        src[0].z     = '0;
        for (int k = 1; k < POLY_TERMS_MAX; k++) begin
            src[k] = r_a[k-1];
        end
        for (int k = 0; k < POLY_TERMS_MAX; k++) begin
            n_a[k] = r_m[k];
            // coefficient a_i is skipped when i is not below the term count
            if ((POLY_TERMS_MAX - 1 - k) < int'(i_cfg.terms)) begin
                n_a[k].z = sat32(46'(r_prod[k] >>> 20)
                           + 46'($signed(i_cfg.coef[POLY_TERMS_MAX-1-k])));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < POLY_TERMS_MAX; k++) begin
                r_m[k].valid <= 1'b0;
                r_a[k].valid <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < POLY_TERMS_MAX; k++) begin
                r_m[k]    <= src[k];
                r_prod[k] <= src[k].z * $signed({1'b0, src[k].r});
                r_a[k]    <= n_a[k];
            end
        end
    end

    assign o_xyz.valid = r_a[POLY_TERMS_MAX-1].valid;
    assign o_xyz.x     = r_a[POLY_TERMS_MAX-1].x;
    assign o_xyz.y     = r_a[POLY_TERMS_MAX-1].y;
    assign o_xyz.z     = r_a[POLY_TERMS_MAX-1].z;

endmodule

[rtl/unp_norm.sv]
// ----------------------------------------------------------------------------
// unp_norm
// Vector normalization: magnitude alignment, pipelined norm square root,
// three pipelined dividers and output saturation. Last stage is the output
// register.
// ----------------------------------------------------------------------------
module unp_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  unp_pkg::t_xyz      i_xyz,
    output logic               o_valid,
    output logic signed [31:0] o_bx,
    output logic signed [31:0] o_by,
    output logic signed [31:0] o_bz
);
    import unp_pkg::*;

    typedef struct packed {
        logic [38:0] ax;
        logic [38:0] ay;
        logic [38:0] az;
        logic        sx;
        logic        sy;
        logic        sz;
    } t_mag;

    typedef struct packed {
        logic [29:0] ax;
        logic [29:0] ay;
        logic [29:0] az;
        logic        sx;
        logic        sy;
        logic        sz;
        logic        zero;
    } t_unit;

    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    t_mag               r_m1, r_m2, r_m3;
    logic [38:0]        r_mx;
    logic [5:0]         r_bits;
    t_unit              r_u4, r_u5;
    logic [59:0]        r_s5x, r_s5y, r_s5z;
    logic [SQ_STAGES:0] r_qv;
    t_sq                r_sq [SQ_STAGES+1];
    t_unit              r_uq [SQ_STAGES+1];
    logic [DIV_STAGES:0] r_dv;
    t_dv                r_dvx [DIV_STAGES+1];
    t_dv                r_dvy [DIV_STAGES+1];
    t_dv                r_dvz [DIV_STAGES+1];
    logic [30:0]        r_dd  [DIV_STAGES+1];
    t_unit              r_ud  [DIV_STAGES+1];
    logic               r_ov;
    logic signed [31:0] r_bx, r_by, r_bz;

    t_mag               n_m1;
    logic [38:0]        n_mx;
    logic [5:0]         n_bits;
    t_unit              n_u4;
    t_sq                n_sq0;
    logic [31:0]        nn;
    logic [60:0]        dvx, dvy, dvz;

    function automatic logic [29:0] align(input logic [38:0] a, input logic [5:0] bits);
        logic [38:0] t;
        if (bits > 6'd30) t = a >> (bits - 6'd30);
        else              t = a << (6'd30 - bits);
        return t[29:0];
    endfunction

    function automatic logic signed [31:0] unit_out(input logic [31:0] q, input logic neg,
                                                   input logic zero);
        logic [31:0] qs;
        qs = (q > 32'h4000_0000) ? 32'h4000_0000 : q;
        if (zero)     return '0;
        else if (neg) return $signed(32'(-qs));
        else          return $signed(qs);
    endfunction

    always_comb begin
        n_m1.ax = i_xyz.x[38] ? 39'(-i_xyz.x) : 39'(i_xyz.x);
        n_m1.ay = i_xyz.y[38] ? 39'(-i_xyz.y) : 39'(i_xyz.y);
        n_m1.az = {3'b000, (i_xyz.z[31] ? 32'(-i_xyz.z) : 32'(i_xyz.z)), 4'b0000};
        n_m1.sx = i_xyz.x[38];
        n_m1.sy = i_xyz.y[38];
        n_m1.sz = i_xyz.z[31];

        n_mx = (r_m1.ax > r_m1.ay) ? r_m1.ax : r_m1.ay;
        if (r_m1.az > n_mx) n_mx = r_m1.az;

        // bit length of the largest magnitude
        n_bits = '0;
        for (int i = 0; i < 39; i++) begin
            if (r_mx[i]) n_bits = 6'(i + 1);
        end

        n_u4.ax   = align(r_m3.ax, r_bits);
        n_u4.ay   = align(r_m3.ay, r_bits);
        n_u4.az   = align(r_m3.az, r_bits);
        n_u4.sx   = r_m3.sx;
        n_u4.sy   = r_m3.sy;
        n_u4.sz   = r_m3.sz;
        n_u4.zero = (r_bits == 6'd0);

        n_sq0.rad  = 64'(r_s5x) + 64'(r_s5y) + 64'(r_s5z);
        n_sq0.rem  = '0;
        n_sq0.root = '0;

        // rounded dividend: (m << 30) + N/2
        nn  = r_sq[SQ_STAGES].root;
        dvx = {1'b0, r_uq[SQ_STAGES].ax, 30'd0} + 61'(nn[31:1]);
        dvy = {1'b0, r_uq[SQ_STAGES].ay, 30'd0} + 61'(nn[31:1]);
        dvz = {1'b0, r_uq[SQ_STAGES].az, 30'd0} + 61'(nn[31:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_qv <= '0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_xyz.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_qv <= {r_qv[SQ_STAGES-1:0], r_v5};
            r_dv <= {r_dv[DIV_STAGES-1:0], r_qv[SQ_STAGES]};
            r_ov <= r_dv[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1   <= n_m1;
            r_m2   <= r_m1;
            r_mx   <= n_mx;
            r_m3   <= r_m2;
            r_bits <= n_bits;
            r_u4   <= n_u4;
            r_s5x  <= r_u4.ax * r_u4.ax;
            r_s5y  <= r_u4.ay * r_u4.ay;
            r_s5z  <= r_u4.az * r_u4.az;
            r_u5   <= r_u4;
            r_sq[0] <= n_sq0;
            r_uq[0] <= r_u5;
            for (int k = 0; k < SQ_STAGES; k++) begin
                r_sq[k+1] <= sq_step(sq_step(r_sq[k]));
                r_uq[k+1] <= r_uq[k];
            end
            r_dvx[0] <= '{low: dvx[31:0], rem: {2'b00, dvx[60:32]}, quo: 32'd0};
            r_dvy[0] <= '{low: dvy[31:0], rem: {2'b00, dvy[60:32]}, quo: 32'd0};
            r_dvz[0] <= '{low: dvz[31:0], rem: {2'b00, dvz[60:32]}, quo: 32'd0};
            r_dd[0]  <= nn[30:0];
            r_ud[0]  <= r_uq[SQ_STAGES];
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dvx[k+1] <= div_step(div_step(r_dvx[k], r_dd[k]), r_dd[k]);
                r_dvy[k+1] <= div_step(div_step(r_dvy[k], r_dd[k]), r_dd[k]);
                r_dvz[k+1] <= div_step(div_step(r_dvz[k], r_dd[k]), r_dd[k]);
                r_dd[k+1]  <= r_dd[k];
                r_ud[k+1]  <= r_ud[k];
            end
            r_bx <= unit_out(r_dvx[DIV_STAGES].quo, r_ud[DIV_STAGES].sx,
                             r_ud[DIV_STAGES].zero);
            r_by <= unit_out(r_dvy[DIV_STAGES].quo, r_ud[DIV_STAGES].sy,
                             r_ud[DIV_STAGES].zero);
            r_bz <= unit_out(r_dvz[DIV_STAGES].quo, r_ud[DIV_STAGES].sz,
                             r_ud[DIV_STAGES].zero);
        end
    end

    assign o_valid = r_ov;
    assign o_bx    = r_bx;
    assign o_by    = r_by;
    assign o_bz    = r_bz;

endmodule

[rtl/omni_pixel_unprojection.sv]
// ----------------------------------------------------------------------------
// omni_pixel_unprojection
// Turns an integer pixel into a unit bearing vector of an omnidirectional
// camera: offset, inverse affine, radius, polynomial, normalization.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// Reset (synchronous, active low) clears all valid bits and loads the
// registers with their defaults: identity affine, zero offsets, five terms.
module omni_pixel_unprojection (
    input logic            i_clk,
    input logic            i_rst_n,
    unp_pix_if.sink        i_pix,
    unp_bear_if.source     o_bear,
    unp_cfg_if.sink        i_cfg
);
    import unp_pkg::*;

    logic [63:0] r_principal, r_row0, r_row1, r_poly01, r_poly23, r_poly45;
    logic [2:0]  r_terms;
    t_cfg        cfg;
    logic        en;
    t_xyr        front_out;
    t_xyz        horner_out;
    logic        norm_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_principal <= 64'd0;
            r_row0      <= 64'h1000_0000_0000_0000;
            r_row1      <= 64'h0000_0000_1000_0000;
            r_poly01    <= 64'd0;
            r_poly23    <= 64'd0;
            r_poly45    <= 64'd0;
            r_terms     <= 3'd5;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_PRINCIPAL: r_principal <= i_cfg.data;
                REG_AFF_ROW0:  r_row0      <= i_cfg.data;
                REG_AFF_ROW1:  r_row1      <= i_cfg.data;
                REG_POLY01:    r_poly01    <= i_cfg.data;
                REG_POLY23:    r_poly23    <= i_cfg.data;
                REG_POLY45:    r_poly45    <= i_cfg.data;
                REG_TERMS:     r_terms     <= i_cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.principal = r_principal;
        cfg.row0      = r_row0;
        cfg.row1      = r_row1;
        cfg.coef[0]   = r_poly01[63:32];
        cfg.coef[1]   = r_poly01[31:0];
        cfg.coef[2]   = r_poly23[63:32];
        cfg.coef[3]   = r_poly23[31:0];
        cfg.coef[4]   = r_poly45[63:32];
        cfg.coef[5]   = r_poly45[31:0];
        cfg.terms     = (r_terms > 3'(POLY_TERMS_MAX)) ? 3'(POLY_TERMS_MAX) : r_terms;
    end

    assign i_cfg.ready = 1'b1;
    assign en          = !norm_valid || o_bear.ready;
    assign i_pix.ready = en;

    unp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_u     (i_pix.pixel_u),
        .i_v     (i_pix.pixel_v),
        .i_cfg   (cfg),
        .o_xyr   (front_out)
    );

    unp_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_xyr   (front_out),
        .i_cfg   (cfg),
        .o_xyz   (horner_out)
    );

    unp_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_xyz   (horner_out),
        .o_valid (norm_valid),
        .o_bx    (o_bear.bearing_x),
        .o_by    (o_bear.bearing_y),
        .o_bz    (o_bear.bearing_z)
    );

    assign o_bear.valid = norm_valid;

endmodule

[rtl/unp_checker.sv]
// ----------------------------------------------------------------------------
// unp_checker
// Port-level checks of the unprojection block, bound to the top level.
// ----------------------------------------------------------------------------
module unp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_cfg_ready,
    input logic signed [31:0] i_bx,
    input logic signed [31:0] i_by,
    input logic signed [31:0] i_bz
);
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // output valid held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("bearing dropped while stalled");

    // pipeline only stalls while a result waits
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config channel not ready");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_bx <= ONE_Q30 && i_bx >= -ONE_Q30 && i_by <= ONE_Q30
                         && i_by >= -ONE_Q30 && i_bz <= ONE_Q30 && i_bz >= -ONE_Q30))
        else $error("bearing component out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind omni_pixel_unprojection unp_checker u_unp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_bear.valid),
    .i_out_ready (o_bear.ready),
    .i_cfg_ready (i_cfg.ready),
    .i_bx        (o_bear.bearing_x),
    .i_by        (o_bear.bearing_y),
    .i_bz        (o_bear.bearing_z)
);

[tb/omni_pixel_unprojection_tb.sv]
// ----------------------------------------------------------------------------
// omni_pixel_unprojection_tb
// Drives pixels through the unprojection pipeline under several register
// settings, predicts each bearing vector in fixed point and checks results.
// ----------------------------------------------------------------------------
module omni_pixel_unprojection_tb;
    import unp_pkg::*;

    typedef struct packed {
        logic [11:0] u;
        logic [11:0] v;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_bearing;

    localparam int LATENCY   = 73;
    localparam int WDOG_MAX  = 20000;

    logic i_clk;
    logic i_rst_n;

    unp_pix_if  pix_ch ();
    unp_bear_if bear_ch ();
    unp_cfg_if  cfg_ch ();

    omni_pixel_unprojection u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch.sink),
        .o_bear  (bear_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // shadow copy of the register file
    logic [63:0] shadow_regs [NUM_REGS];

    t_pixel   pixel_q [$];
    t_bearing bearing_q [$];
    int       errors;
    int       n_pixels;
    int       n_bearings;
    int       n_cfg_writes;
    int       wdog;
    bit       hold_off;
    bit       long_hold_done;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint fshr(longint a, int s);
        return a >>> s;
    endfunction

    function automatic longint sat32(longint a);
        if (a > 64'sd2147483647) return 64'sd2147483647;
        if (a < -64'sd2147483648) return -64'sd2147483648;
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    function automatic logic [31:0] unit_component(longint unsigned m, bit neg,
                                                   longint unsigned nrm);
        longint unsigned q;
        q = ((m << 30) + (nrm >> 1)) / nrm;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        return neg ? 32'(-q) : 32'(q);
    endfunction

    function automatic longint coef_at(int i);
        logic [63:0] r;
        if (i >= POLY_TERMS_MAX) return 0;
        r = shadow_regs[int'(REG_POLY01) + i / 2];
        return (i % 2) ? longint'($signed(r[31:0])) : longint'($signed(r[63:32]));
    endfunction

    function automatic t_bearing unproject(t_pixel p);
        longint          cx, cy, dx, dy, m00, m01, m10, m11, x, y, r, z;
        longint unsigned px, py, ax, ay, az, mx, nrm;
        int              nterms, bits;
        t_bearing        res;
        cx  = longint'(shadow_regs[REG_PRINCIPAL][63:32]);
        cy  = longint'(shadow_regs[REG_PRINCIPAL][31:0]);
        dx  = longint'(p.u) * 1048576 - cx;
        dy  = longint'(p.v) * 1048576 - cy;
        m00 = $signed(shadow_regs[REG_AFF_ROW0][63:32]);
        m01 = $signed(shadow_regs[REG_AFF_ROW0][31:0]);
        m10 = $signed(shadow_regs[REG_AFF_ROW1][63:32]);
        m11 = $signed(shadow_regs[REG_AFF_ROW1][31:0]);
        x   = fshr(m00 * dx, 28) + fshr(m01 * dy, 28);
        y   = fshr(m10 * dx, 28) + fshr(m11 * dy, 28);
        px  = magnitude(fshr(x, 8));
        py  = magnitude(fshr(y, 8));
        r   = longint'(int_sqrt(px * px + py * py));
        nterms = int'(shadow_regs[REG_TERMS][2:0]);
        if (nterms > POLY_TERMS_MAX) nterms = POLY_TERMS_MAX;
        z = 0;
        for (int i = nterms; i > 0; i--)
            z = sat32(fshr(z * r, 20) + coef_at(i - 1));
        ax = magnitude(x);
        ay = magnitude(y);
        az = magnitude(z) << 4;
        mx = (ax > ay) ? ax : ay;
        if (az > mx) mx = az;
        if (mx == 0) return '0;
        bits = 0;
        while ((mx >> bits) != 0) bits++;
        if (bits > 30) begin
            ax = ax >> (bits - 30); ay = ay >> (bits - 30); az = az >> (bits - 30);
        end else begin
            ax = ax << (30 - bits); ay = ay << (30 - bits); az = az << (30 - bits);
        end
        nrm = int_sqrt(ax * ax + ay * ay + az * az);
        res.x = unit_component(ax, x < 0, nrm);
        res.y = unit_component(ay, y < 0, nrm);
        res.z = unit_component(az, z < 0, nrm);
        return res;
    endfunction

    // ---------------- driver ----------------
    int  burst_left;
    int  gap_left;
    bit  drive_en;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.valid <= 1'b0;
            burst_left   <= 0;
            gap_left     <= 0;
        end else begin
            // the driven pixel stays at the head of the queue until accepted
            if (pix_ch.valid && pix_ch.ready) begin
                bearing_q.insert(bearing_q.size(), unproject(pixel_q.pop_front()));
                n_pixels <= n_pixels + 1;
            end
            if (pix_ch.valid && !pix_ch.ready) begin
                // hold the current transaction
            end else if (drive_en && pixel_q.size() > 0 && gap_left == 0) begin
                pix_ch.valid   <= 1'b1;
                pix_ch.pixel_u <= pixel_q[0].u;
                pix_ch.pixel_v <= pixel_q[0].v;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                pix_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // ---------------- monitor ----------------
    int stall_mode;
    int stall_cnt;

    always @(posedge i_clk) begin
        t_bearing want;
        if (!i_rst_n) begin
            bear_ch.ready <= 1'b0;
            stall_cnt     <= 0;
        end else begin
            if (bear_ch.valid && bear_ch.ready) begin
                n_bearings <= n_bearings + 1;
                if (bearing_q.size() == 0) begin
                    $display("%0t: bearing with nothing expected: got %h %h %h", $time,
                             bear_ch.bearing_x, bear_ch.bearing_y, bear_ch.bearing_z);
                    errors = errors + 1;
                end else begin
                    want = bearing_q.pop_front();
                    if (want.x !== bear_ch.bearing_x) begin
                        $display("%0t: bearing_x expected %0d actual %0d", $time,
                                 want.x, bear_ch.bearing_x);
                        errors = errors + 1;
                    end
                    if (want.y !== bear_ch.bearing_y) begin
                        $display("%0t: bearing_y expected %0d actual %0d", $time,
                                 want.y, bear_ch.bearing_y);
                        errors = errors + 1;
                    end
                    if (want.z !== bear_ch.bearing_z) begin
                        $display("%0t: bearing_z expected %0d actual %0d", $time,
                                 want.z, bear_ch.bearing_z);
                        errors = errors + 1;
                    end
                end
            end
            // stall pattern: phases of always-ready, random and sparse acceptance
            if (hold_off) begin
                bear_ch.ready <= 1'b0;
            end else begin
                if (stall_cnt == 0) begin
                    stall_mode <= $urandom_range(2, 0);
                    stall_cnt  <= $urandom_range(80, 10);
                end else begin
                    stall_cnt <= stall_cnt - 1;
                end
                unique case (stall_mode)
                    0: bear_ch.ready <= 1'b1;
                    1: bear_ch.ready <= $urandom_range(1, 0);
                    default: bear_ch.ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    // one long hold-off while the sender keeps offering
    initial begin
        hold_off = 1'b0;
        long_hold_done = 1'b0;
        wait (n_pixels > 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
        long_hold_done = 1'b1;
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (bear_ch.valid && bear_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || hold_off) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("%0t: watchdog expired, %0d bearings outstanding", $time,
                         bearing_q.size());
                $display("[omni_pixel_unprojection] ERROR");
                $finish;
            end
        end
    end

    // ---------------- configuration ----------------
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        shadow_regs[idx] = (idx == REG_TERMS) ? {61'd0, val[2:0]} : val;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        wait (pixel_q.size() == 0 && !pix_ch.valid && bearing_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(3, 0))
            0: return 32'(int'($urandom_range(131072)) - 65536);
            1: return 32'(int'($urandom_range(2000)) - 1000);
            2: return $urandom();
            default: return ($urandom_range(1, 0)) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_affine();
        case ($urandom_range(3, 0))
            0: return 32'h1000_0000 + 32'(int'($urandom_range(4000000)) - 2000000);
            1: return 32'(int'($urandom_range(8000000)) - 4000000);
            2: return $urandom();
            default: return ($urandom_range(1, 0)) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    task automatic queue_pixel(logic [11:0] u, logic [11:0] v);
        t_pixel p;
        p.u = u;
        p.v = v;
        pixel_q.insert(pixel_q.size(), p);
    endtask

    initial begin
        logic [11:0] u, v;
        errors = 0;
        n_pixels = 0;
        n_bearings = 0;
        n_cfg_writes = 0;
        drive_en = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_u = '0;
        pix_ch.pixel_v = '0;
        bear_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        shadow_regs[REG_PRINCIPAL] = 64'd0;
        shadow_regs[REG_AFF_ROW0]  = 64'd1152921504606846976;
        shadow_regs[REG_AFF_ROW1]  = 64'd268435456;
        shadow_regs[REG_POLY01]    = 64'd0;
        shadow_regs[REG_POLY23]    = 64'd0;
        shadow_regs[REG_POLY45]    = 64'd0;
        shadow_regs[REG_TERMS]     = 64'd5;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: zero polynomial, pixel at origin gives the zero vector
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd4095, 12'd0);
        queue_pixel(12'd0, 12'd4095);
        drive_en = 1'b1;
        drain();

        // typical lens around image center
        write_reg(REG_PRINCIPAL, {32'(2048 << 20), 32'(1536 << 20)});
        write_reg(REG_POLY01, {32'hFFA0_0000, 32'h0000_0000});
        write_reg(REG_POLY23, {32'h0000_1000, 32'hFFFF_F800});
        write_reg(REG_POLY45, {32'h0000_0010, 32'h0000_0004});
        write_reg(REG_TERMS, 64'd6);
        queue_pixel(12'd2048, 12'd1536);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'd2048, 12'd0);
        queue_pixel(12'd2049, 12'd1536);
        drain();

        // zero terms, then too many terms (clamped)
        write_reg(REG_TERMS, 64'd0);
        queue_pixel(12'd2048, 12'd1536);
        queue_pixel(12'd100, 12'd3000);
        drain();
        write_reg(REG_TERMS, 64'd7);
        queue_pixel(12'd100, 12'd3000);
        queue_pixel(12'd2048, 12'd1536);
        drain();

        // extreme registers: saturation of outputs
        write_reg(REG_PRINCIPAL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_AFF_ROW0, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_AFF_ROW1, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_POLY01, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_POLY23, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(REG_POLY45, {32'h8000_0000, 32'h8000_0000});
        write_reg(REG_TERMS, 64'd1);
        queue_pixel(12'd0, 12'd0);
        queue_pixel(12'd4095, 12'd4095);
        queue_pixel(12'hAAA, 12'h555);
        queue_pixel(12'h555, 12'hAAA);
        drain();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_PRINCIPAL, {$urandom(), $urandom()});
            if (ph % 2 == 0)
                write_reg(REG_PRINCIPAL,
                          {32'($urandom_range(4095)) << 20 | 32'($urandom_range(1048575)),
                           32'($urandom_range(4095)) << 20 | 32'($urandom_range(1048575))});
            write_reg(REG_AFF_ROW0, {rand_affine(), rand_affine()});
            write_reg(REG_AFF_ROW1, {rand_affine(), rand_affine()});
            write_reg(REG_POLY01, {rand_q16(), rand_q16()});
            write_reg(REG_POLY23, {rand_q16(), rand_q16()});
            write_reg(REG_POLY45, {rand_q16(), rand_q16()});
            write_reg(REG_TERMS, 64'($urandom_range(7)));
            for (int k = 0; k < 172; k++) begin
                u = 12'($urandom());
                v = 12'($urandom());
                queue_pixel(u, v);
            end
            drain();
        end
        wait (long_hold_done);
        drain();

        $display("Covered %0d pixels, %0d bearings checked, %0d register writes.",
                 n_pixels, n_bearings, n_cfg_writes);
        if (errors == 0) begin
            $display("[omni_pixel_unprojection] OK");
        end else begin
            $display("[omni_pixel_unprojection] ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/unp_pkg.sv
rtl/unp_if.sv
rtl/unp_front.sv
rtl/unp_horner.sv
rtl/unp_norm.sv
rtl/omni_pixel_unprojection.sv
rtl/unp_checker.sv
tb/omni_pixel_unprojection_tb.sv
